// ===== sv/php_pkg.sv =====
package php_pkg;

	localparam int HOST_TEXT_MAX   = 256;
	localparam int AGENT_TEXT_MAX  = 256;
	localparam int MAX_FRAME_BYTES = 65535;

	localparam int TEXT_MAX = (HOST_TEXT_MAX > AGENT_TEXT_MAX) ? HOST_TEXT_MAX : AGENT_TEXT_MAX;
	localparam int CNT_W    = $clog2(TEXT_MAX);

	localparam logic [CNT_W-1:0] HOST_LIMIT  = CNT_W'(HOST_TEXT_MAX - 1);
	localparam logic [CNT_W-1:0] AGENT_LIMIT = CNT_W'(AGENT_TEXT_MAX - 1);
	localparam logic [15:0]      POS_LIMIT   = 16'(MAX_FRAME_BYTES);

	localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
	localparam logic [7:0]  PROTO_TCP  = 8'd6;
	localparam logic [7:0]  PROTO_UDP  = 8'd17;
	localparam logic [15:0] PORT_RESET = 16'd80;
	localparam logic [7:0]  CHAR_CR    = 8'h0d;
	localparam logic [7:0]  CHAR_LF    = 8'h0a;

	localparam logic [31:0] PAT_GET   = "GET ";
	localparam logic [39:0] PAT_POST  = "POST ";
	localparam logic [47:0] PAT_HOST  = "Host: ";
	localparam logic [95:0] PAT_AGENT = "User-Agent: ";

	localparam logic [1:0] KIND_SUMMARY = 2'd0;
	localparam logic [1:0] KIND_HOST    = 2'd1;
	localparam logic [1:0] KIND_AGENT   = 2'd2;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef enum logic [1:0] {PH_SEARCH, PH_COPY, PH_DONE} phase_t;
	typedef enum logic [1:0] {ST_UNDECIDED, ST_REQUEST, ST_NOT_REQUEST} status_t;

	typedef struct packed {
		logic [47:0] source_mac;
		logic [47:0] destination_mac;
		logic [31:0] source_ip;
		logic [31:0] destination_ip;
		logic [7:0]  ip_protocol;
		logic [15:0] source_port;
		logic [15:0] destination_port;
		logic [7:0]  tcp_flag_bits;
		logic        http_request;
		logic        ipv4_frame;
	} summary_t;

	typedef struct packed {
		logic     host;
		logic     agent;
		logic     last;
		logic [7:0] text;
		summary_t sum;
	} event_t;

	typedef struct packed {
		phase_t           phase;
		logic [CNT_W-1:0] count;
		logic             emit;
	} scan_t;

	function automatic scan_t scan_text(phase_t phase, logic [CNT_W-1:0] count,
			logic [CNT_W-1:0] limit, logic match, logic [7:0] b, logic searchable);
		scan_t r;
		r.phase = phase;
		r.count = count;
		r.emit  = 1'b0;
		if (phase == PH_COPY) begin
			if (b == 8'd0 || b == CHAR_CR || b == CHAR_LF) begin
				r.phase = PH_DONE;
			end else begin
				r.count = count + 1'b1;
				r.emit  = 1'b1;
				if (r.count >= limit) r.phase = PH_DONE;
			end
		end else if (phase == PH_SEARCH && searchable && b != 8'd0 && match) begin
			r.phase = PH_COPY;
			r.count = '0;
		end
		return r;
	endfunction

endpackage

// ===== sv/packet_header_and_http_parser_top.sv =====
// Ethernet/IPv4/TCP/UDP header parser with HTTP Host and User-Agent extraction.
// Input channel: in_valid/in_stall with data_byte and last_byte, one frame byte
// per transaction starting at the destination MAC. The block takes one byte
// every cycle while its internal four-entry queue has room.
// Output channel: out_valid/out_stall; each transaction is a host text byte,
// a user agent text byte or, on the frame's last byte, the frame summary.
// A result is queued at the edge that accepts its byte and is then registered
// at the output when the queue ahead of it is empty and the output is free.
// Throughput: one byte per cycle in while the queue has room; one result per
// cycle out while the output is not stalled, so a byte with two results (text
// plus summary, or host plus agent) sends them in turn; the queue absorbs it.
// Configuration: cfg_valid/cfg_ready with listen_port, always ready; write only
// while idle.
// Reset clears all frame state, the queue and out_valid, and sets the listen
// port to 80. While out_stall is high the output transaction holds, the queue
// fills, and in_stall rises once it is full.
module packet_header_and_http_parser_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_stall,
	input  logic [7:0]   data_byte,
	input  logic         last_byte,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [15:0]  listen_port,
	output logic         out_valid,
	input  logic         out_stall,
	output logic [1:0]   item_kind,
	output logic [7:0]   text_byte,
	output logic [47:0]  source_mac,
	output logic [47:0]  destination_mac,
	output logic [31:0]  source_ip,
	output logic [31:0]  destination_ip,
	output logic [7:0]   ip_protocol,
	output logic [15:0]  source_port,
	output logic [15:0]  destination_port,
	output logic [7:0]   tcp_flag_bits,
	output logic         http_request,
	output logic         ipv4_frame
);
	import php_pkg::*;

	logic [15:0] port_q;
	logic        full, empty, push, pop, accept;
	event_t      push_ev, head_ev;
	summary_t    sum;

	assign cfg_ready = 1'b1;
	assign in_stall  = full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) port_q <= PORT_RESET;
		else if (cfg_valid && cfg_ready) port_q <= listen_port;
	end

	php_front u_front (
		.clk, .arst_n, .in_valid, .data_byte, .last_byte, .full,
		.listen_port(port_q), .accept, .push, .ev(push_ev)
	);

	php_queue u_queue (
		.clk, .arst_n, .push, .push_ev, .pop, .head_ev, .empty, .full
	);

	php_back u_back (
		.clk, .arst_n, .head_ev, .empty, .pop, .out_valid, .out_stall,
		.item_kind, .text_byte, .sum
	);

	assign source_mac       = sum.source_mac;
	assign destination_mac  = sum.destination_mac;
	assign source_ip        = sum.source_ip;
	assign destination_ip   = sum.destination_ip;
	assign ip_protocol      = sum.ip_protocol;
	assign source_port      = sum.source_port;
	assign destination_port = sum.destination_port;
	assign tcp_flag_bits    = sum.tcp_flag_bits;
	assign http_request     = sum.http_request;
	assign ipv4_frame       = sum.ipv4_frame;

	a_accept_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !full)
		else $error("byte taken while queue full");
	a_push_needs_accept: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (in_valid && !in_stall))
		else $error("queue written without input transaction");
	a_last_pushes: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && last_byte) |-> push)
		else $error("last byte did not queue a summary");

endmodule

// ===== sv/php_front.sv =====
module php_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [7:0]           data_byte,
	input  logic                 last_byte,
	input  logic                 full,
	input  logic [15:0]          listen_port,
	output logic                 accept,
	output logic                 push,
	output php_pkg::event_t      ev
);
	import php_pkg::*;

	logic [15:0] pos_q, ip_end_q, th_end_q, etype_q;
	logic [47:0] dmac_q, smac_q;
	logic [31:0] sip_q, dip_q;
	logic [15:0] sport_q, dport_q;
	logic [7:0]  flags_q, proto_q;
	logic [87:0] win_q;
	status_t     status_q;
	phase_t      hphase_q, aphase_q;
	logic [CNT_W-1:0] hcount_q, acount_q;
	logic        nul_q;

	logic [15:0] d_pos, d_ip_end, d_th_end, d_etype;
	logic [47:0] d_dmac, d_smac;
	logic [31:0] d_sip, d_dip;
	logic [15:0] d_sport, d_dport;
	logic [7:0]  d_flags, d_proto;
	logic [87:0] d_win;
	status_t     d_status;
	phase_t      d_hphase, d_aphase;
	logic [CNT_W-1:0] d_hcount, d_acount;
	logic        d_nul;
	logic        eh, ea;

	logic [15:0] k_ip, k_pl, i;
	logic [95:0] buf_v;
	logic [3:0]  nib;
	logic [31:0] ports;
	scan_t       sh, sa;

	assign accept = in_valid && !full;
	assign i      = pos_q;
	assign k_ip   = pos_q - ip_end_q;
	assign k_pl   = pos_q - th_end_q;
	assign buf_v  = {win_q, data_byte};

	always_comb begin
		d_pos = pos_q; d_ip_end = ip_end_q; d_th_end = th_end_q; d_etype = etype_q;
		d_dmac = dmac_q; d_smac = smac_q; d_sip = sip_q; d_dip = dip_q;
		d_sport = sport_q; d_dport = dport_q; d_flags = flags_q; d_proto = proto_q;
		d_win = win_q; d_status = status_q; d_hphase = hphase_q; d_aphase = aphase_q;
		d_hcount = hcount_q; d_acount = acount_q; d_nul = nul_q;
		eh = 1'b0; ea = 1'b0;
		nib = 4'd0; ports = '0; sh = '0; sa = '0;
		if (pos_q < POS_LIMIT) begin
			d_pos = pos_q + 16'd1;
			if (i < 16'd6) begin
				d_dmac = {dmac_q[39:0], data_byte};
			end else if (i < 16'd12) begin
				d_smac = {smac_q[39:0], data_byte};
			end else if (i == 16'd12) begin
				d_etype = {data_byte, 8'd0};
			end else if (i == 16'd13) begin
				d_etype = {etype_q[15:8], data_byte};
			end else if (etype_q != ETYPE_IPV4) begin
				d_etype = etype_q;
			end else if (i == 16'd14) begin
				nib = (data_byte[3:0] < 4'd5) ? 4'd5 : data_byte[3:0];
				d_ip_end = 16'd14 + {10'd0, nib, 2'b00};
			end else if (i == 16'd23) begin
				d_proto = data_byte;
			end else if (i >= 16'd26 && i < 16'd30) begin
				d_sip = {sip_q[23:0], data_byte};
			end else if (i >= 16'd30 && i < 16'd34) begin
				d_dip = {dip_q[23:0], data_byte};
			end else if (ip_end_q != 16'd0 && i >= ip_end_q &&
					(proto_q == PROTO_TCP || proto_q == PROTO_UDP)) begin
				if (k_ip < 16'd4) begin
					ports   = {sport_q[7:0], dport_q, data_byte};
					d_sport = ports[31:16];
					d_dport = ports[15:0];
					if (proto_q == PROTO_UDP && k_ip == 16'd0) d_th_end = ip_end_q + 16'd8;
				end else if (proto_q == PROTO_UDP) begin
					d_proto = proto_q;
				end else if (k_ip == 16'd12) begin
					nib = (data_byte[7:4] < 4'd5) ? 4'd5 : data_byte[7:4];
					d_th_end = ip_end_q + {10'd0, nib, 2'b00};
				end else if (k_ip == 16'd13) begin
					d_flags = data_byte;
				end else if (th_end_q != 16'd0 && i >= th_end_q) begin
					d_win = {win_q[79:0], data_byte};
					if (status_q == ST_UNDECIDED) begin
						if (sport_q != listen_port && dport_q != listen_port)
							d_status = ST_NOT_REQUEST;
						else if (k_pl == 16'd3 && buf_v[31:0] == PAT_GET)
							d_status = ST_REQUEST;
						else if (k_pl >= 16'd4)
							d_status = (buf_v[39:0] == PAT_POST) ? ST_REQUEST : ST_NOT_REQUEST;
					end
					if (d_status == ST_REQUEST) begin
						sh = scan_text(hphase_q, hcount_q, HOST_LIMIT,
							buf_v[47:0] == PAT_HOST, data_byte, !nul_q);
						sa = scan_text(aphase_q, acount_q, AGENT_LIMIT,
							buf_v == PAT_AGENT, data_byte, !nul_q);
						d_hphase = sh.phase; d_hcount = sh.count; eh = sh.emit;
						d_aphase = sa.phase; d_acount = sa.count; ea = sa.emit;
					end
					if (data_byte == 8'd0) d_nul = 1'b1;
				end
			end
		end
	end

	always_comb begin
		ev.host  = eh;
		ev.agent = ea && !(last_byte && eh);
		ev.last  = last_byte;
		ev.text  = data_byte;
		ev.sum.source_mac       = d_smac;
		ev.sum.destination_mac  = d_dmac;
		ev.sum.source_ip        = d_sip;
		ev.sum.destination_ip   = d_dip;
		ev.sum.ip_protocol      = d_proto;
		ev.sum.source_port      = d_sport;
		ev.sum.destination_port = d_dport;
		ev.sum.tcp_flag_bits    = d_flags;
		ev.sum.http_request     = (d_status == ST_REQUEST);
		ev.sum.ipv4_frame       = (d_pos >= 16'd14) && (d_etype == ETYPE_IPV4);
		push = accept && (ev.host || ev.agent || ev.last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0; ip_end_q <= '0; th_end_q <= '0; etype_q <= '0;
			dmac_q <= '0; smac_q <= '0; sip_q <= '0; dip_q <= '0;
			sport_q <= '0; dport_q <= '0; flags_q <= '0; proto_q <= '0;
			win_q <= '0; status_q <= ST_UNDECIDED; hphase_q <= PH_SEARCH;
			aphase_q <= PH_SEARCH; hcount_q <= '0; acount_q <= '0; nul_q <= 1'b0;
		end else if (accept && last_byte) begin
			pos_q <= '0; ip_end_q <= '0; th_end_q <= '0; etype_q <= '0;
			dmac_q <= '0; smac_q <= '0; sip_q <= '0; dip_q <= '0;
			sport_q <= '0; dport_q <= '0; flags_q <= '0; proto_q <= '0;
			win_q <= '0; status_q <= ST_UNDECIDED; hphase_q <= PH_SEARCH;
			aphase_q <= PH_SEARCH; hcount_q <= '0; acount_q <= '0; nul_q <= 1'b0;
		end else if (accept) begin
			pos_q <= d_pos; ip_end_q <= d_ip_end; th_end_q <= d_th_end; etype_q <= d_etype;
			dmac_q <= d_dmac; smac_q <= d_smac; sip_q <= d_sip; dip_q <= d_dip;
			sport_q <= d_sport; dport_q <= d_dport; flags_q <= d_flags; proto_q <= d_proto;
			win_q <= d_win; status_q <= d_status; hphase_q <= d_hphase;
			aphase_q <= d_aphase; hcount_q <= d_hcount; acount_q <= d_acount; nul_q <= d_nul;
		end
	end

endmodule

// ===== sv/php_queue.sv =====
module php_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  php_pkg::event_t push_ev,
	input  logic            pop,
	output php_pkg::event_t head_ev,
	output logic            empty,
	output logic            full
);
	import php_pkg::*;

	event_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_q, rd_q;
	logic [QPTR_W:0]    cnt_q;

	assign empty   = (cnt_q == '0);
	assign full    = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign head_ev = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_ev;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0; rd_q <= '0; cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) full |-> !push)
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) empty |-> !pop)
		else $error("queue read while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (QPTR_W+1)'(QUEUE_DEPTH))
		else $error("queue count out of range");

endmodule

// ===== sv/php_back.sv =====
module php_back (
	input  logic            clk,
	input  logic            arst_n,
	input  php_pkg::event_t head_ev,
	input  logic            empty,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [1:0]      item_kind,
	output logic [7:0]      text_byte,
	output php_pkg::summary_t sum
);
	import php_pkg::*;

	logic [2:0] done_q, want, pend, sel, next_done;
	logic       load;

	assign want = empty ? 3'b000 : {head_ev.host, head_ev.agent, head_ev.last};
	assign pend = want & ~done_q;
	assign load = (pend != 3'b000) && (!out_valid || !out_stall);

	always_comb begin
		sel = 3'b000;
		if (pend[2]) sel = 3'b100;
		else if (pend[1]) sel = 3'b010;
		else if (pend[0]) sel = 3'b001;
		next_done = done_q | sel;
		pop = load && (next_done == want);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= '0; out_valid <= 1'b0;
		end else begin
			if (load) done_q <= pop ? 3'b000 : next_done;
			if (load) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (sel[0]) begin
				item_kind <= KIND_SUMMARY; text_byte <= 8'd0; sum <= head_ev.sum;
			end else begin
				item_kind <= sel[2] ? KIND_HOST : KIND_AGENT;
				text_byte <= head_ev.text;
				sum <= '0;
			end
		end
	end

	a_one_sel: assert property (@(posedge clk) disable iff (!arst_n) $onehot0(sel))
		else $error("more than one item selected");
	a_done_subset: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> ((done_q & ~want) == 3'b000))
		else $error("completed item not requested by head");
	a_summary_text: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && item_kind == KIND_SUMMARY) |-> text_byte == 8'd0)
		else $error("summary carries text");

endmodule
